### rtl/tsr_pkg.sv
// Shared types, constants and helper functions for the three-shear rotation mapper.
// Used by tsr_front, tsr_back, three_shear_rotation_mapper, tsr_checker and tb_top.
// Depends on nothing else.
package tsr_pkg;

    // Field widths.
    localparam int PIX_W      = 8;
    localparam int SRC_W      = 9;
    localparam int DST_W      = 10;
    localparam int ADDR_W     = 20;
    localparam int COEF_W     = 16;
    localparam int CRD0_W     = SRC_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SHEAR_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHEAR_B    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR     = 3'd6;

    // Register reset values.
    localparam logic [SRC_W-1:0] SRC_DIM_RESET = 9'd2;
    localparam logic [DST_W-1:0] DST_DIM_RESET = 10'd4;

    // Source dimension limits.
    localparam logic [SRC_W-1:0] MIN_SRC_DIM = 9'd2;
    localparam int               MAX_SRC_DIM = 511;

    // Default fraction bits of the shear coefficients.
    localparam int FRAC_BITS_DEF = 14;

    // Queue sizes.
    localparam int MID_DEPTH_LOG2 = 2;
    localparam int OUT_DEPTH_LOG2 = 4;
    localparam int OUT_DEPTH      = 1 << OUT_DEPTH_LOG2;

    // Configuration as seen by the datapath (source sizes already clamped).
    typedef struct packed {
        logic signed [COEF_W-1:0] shear_a;
        logic signed [COEF_W-1:0] shear_b;
        logic [SRC_W-1:0]         src_width;
        logic [SRC_W-1:0]         src_height;
        logic [DST_W-1:0]         dst_width;
        logic [DST_W-1:0]         dst_height;
        logic                     mirror_flip;
    } cfg_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic signed [CRD0_W-1:0] x;
        logic signed [CRD0_W-1:0] y;
        logic [PIX_W-1:0]         pixel;
        logic                     last;
    } item_t;

    // Finished result waiting for the consumer.
    typedef struct packed {
        logic [ADDR_W-1:0] write_addr;
        logic [PIX_W-1:0]  pixel;
        logic              addr_valid;
        logic              last;
    } result_t;

    // Clamp a source dimension into the supported range.
    function automatic logic [SRC_W-1:0] clamp_dim(input logic [SRC_W-1:0] d);
        logic [SRC_W-1:0] r;
        r = d;
        if (r < MIN_SRC_DIM)
        begin
            r = MIN_SRC_DIM;
        end
        if ({1'b0, r} > (SRC_W + 1)'(MAX_SRC_DIM))
        begin
            r = SRC_W'(MAX_SRC_DIM);
        end
        return r;
    endfunction

endpackage

### rtl/tsr_fifo.sv
// Small first-in first-out queue built from registers.
// Used for the queue between front and back and for the result queue.
// Depends on nothing else.
module tsr_fifo #(
    parameter int WIDTH      = 8,
    parameter int DEPTH_LOG2 = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  full,
    output logic                  empty,
    output logic [DEPTH_LOG2:0]   count
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [WIDTH-1:0]      mem_reg [DEPTH];
    logic [DEPTH_LOG2-1:0] wr_ptr_reg, wr_ptr_next;
    logic [DEPTH_LOG2-1:0] rd_ptr_reg, rd_ptr_next;
    logic [DEPTH_LOG2:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    // Handshake qualification and status.
    assign full    = (count_reg == (DEPTH_LOG2 + 1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (DEPTH_LOG2 + 1)'(do_push) - (DEPTH_LOG2 + 1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/tsr_front.sv
// Front end: accepts source pixels and walks the centered source coordinates.
// Produces one classified item per accepted pixel for the back end.
// Depends on tsr_pkg.
module tsr_front
    import tsr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   accept,
    input  logic [PIX_W-1:0] pixel_in,
    input  cfg_t   cfg,
    output item_t  item
);

    logic [SRC_W-1:0]   col_count_reg, col_count_next;
    logic [SRC_W-1:0]   row_count_reg, row_count_next;
    logic [SRC_W-2:0]   wh, hh;
    logic [SRC_W-1:0]   col_last, row_last;
    logic [SRC_W-1:0]   c, r;
    logic               col_end, row_end;

    // Half sizes and the last position of each counter.
    assign wh       = cfg.src_width[SRC_W-1:1];
    assign hh       = cfg.src_height[SRC_W-1:1];
    assign col_last = {wh, 1'b0} - 1'b1;
    assign row_last = {hh, 1'b0} - 1'b1;

    // A counter left beyond the frame by a size change acts as its last position.
    assign c       = (col_count_reg > col_last) ? col_last : col_count_reg;
    assign r       = (row_count_reg > row_last) ? row_last : row_count_reg;
    assign col_end = (c == col_last);
    assign row_end = (r == row_last);

    // Centered coordinates and frame end flag.
    always_comb
    begin
        item.x     = $signed({1'b0, c}) - $signed({2'b00, wh});
        item.y     = $signed({1'b0, r}) - $signed({2'b00, hh});
        item.pixel = pixel_in;
        item.last  = col_end && row_end;
    end

    // Raster counters.
    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (col_end)
            begin
                col_count_next = '0;
                row_count_next = row_end ? '0 : r + 1'b1;
            end
            else
            begin
                col_count_next = c + 1'b1;
                row_count_next = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

`ifndef SYNTH
    // The frame end item must restart both counters.
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.last |=> col_count_reg == '0 && row_count_reg == '0)
        else $error("counters did not wrap after the last pixel");
`endif

endmodule

### rtl/tsr_back.sv
// Back end: three-shear rotation pipeline, offsets, mirroring and address forming.
// Issues items from the middle queue only when the result queue has room for them.
// Depends on tsr_pkg.
module tsr_back
    import tsr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    q_empty,
    input  item_t                   q_item,
    output logic                    q_pop,
    input  logic [OUT_DEPTH_LOG2:0] out_count,
    output logic                    out_push,
    output result_t                 out_data
);

    // Growth in bits of one shear, from the largest coefficient magnitude.
    localparam int G      = (FRAC_BITS < 15) ? (16 - FRAC_BITS) : 1;
    localparam int CW     = CRD0_W - 1 + 3 * G;
    localparam int PRW    = COEF_W + CW;
    localparam int SW     = CW + FRAC_BITS + COEF_W;
    localparam int PW     = CW + 3;
    localparam int STAGES = 9;
    localparam int IF_W   = $clog2(STAGES + 1);
    localparam logic [SW-1:0] RND = (SW'(1) << FRAC_BITS) - SW'(1);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } meta_t;

    // One shear: base + k*other, truncated toward zero.
    function automatic logic signed [CW-1:0] shear_sum(
        input logic signed [CW-1:0]  base,
        input logic signed [PRW-1:0] p
    );
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] adj;
        s   = (SW'(base) <<< FRAC_BITS) + SW'(p);
        adj = s + (s[SW-1] ? $signed(RND) : $signed(SW'(0)));
        return CW'(adj >>> FRAC_BITS);
    endfunction

    logic [STAGES-1:0] vld_reg, vld_next;
    logic [IF_W-1:0]   inflight_reg, inflight_next;
    meta_t             meta_reg [STAGES];

    logic signed [CRD0_W-1:0] s0_x_reg, s0_y_reg, s1_x_reg, s1_y_reg, s2_y_reg, s3_y_reg;
    logic signed [PRW-1:0]    s1_p_reg, s3_p_reg, s5_p_reg;
    logic signed [CW-1:0]     s2_x_reg, s3_x_reg, s4_x_reg, s4_y_reg, s5_x_reg, s5_y_reg;
    logic signed [CW-1:0]     s6_x_reg, s6_y_reg;
    logic [DST_W-1:0]         s7_col_reg, s7_row_reg, s8_col_reg;
    logic                     s7_valid_reg, s8_valid_reg;
    logic [ADDR_W-1:0]        s8_prod_reg;

    logic                     credit;
    logic signed [DST_W+1:0]  dx, dy, dx_adj, dy_adj, off_x, off_y;
    logic signed [DST_W-1:0]  wh_s, hh_s;
    logic signed [DST_W:0]    dw_s, dh_s;
    logic signed [PW-1:0]     col_s, row_s, col_m, row_m;
    logic                     pos_valid;

    // Issue only when every item in flight is sure of a place in the result queue.
    assign credit   = (int'(out_count) + int'(inflight_reg)) < OUT_DEPTH;
    assign q_pop    = !q_empty && credit;
    assign out_push = vld_reg[STAGES-1];

    // Control: stage valid bits and the in-flight count.
    always_comb
    begin
        vld_next      = {vld_reg[STAGES-2:0], q_pop};
        inflight_next = inflight_reg + IF_W'(q_pop) - IF_W'(out_push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            vld_reg      <= vld_next;
            inflight_reg <= inflight_next;
        end
    end

    // Pixel and frame end flag travel alongside the coordinates.
    always_ff @(posedge clk)
    begin
        meta_reg[0] <= '{pixel: q_item.pixel, last: q_item.last};
        for (int i = 1; i < STAGES; i++)
        begin
            meta_reg[i] <= meta_reg[i-1];
        end
    end

    // Destination offsets, truncated toward zero, and centering terms.
    always_comb
    begin
        wh_s   = $signed({2'b00, cfg.src_width[SRC_W-1:1]});
        hh_s   = $signed({2'b00, cfg.src_height[SRC_W-1:1]});
        dw_s   = $signed({1'b0, cfg.dst_width});
        dh_s   = $signed({1'b0, cfg.dst_height});
        dx     = $signed({2'b00, cfg.dst_width}) - $signed({3'b000, cfg.src_width});
        dy     = $signed({2'b00, cfg.dst_height}) - $signed({3'b000, cfg.src_height});
        dx_adj = dx + $signed({{(DST_W+1){1'b0}}, dx[DST_W+1]});
        dy_adj = dy + $signed({{(DST_W+1){1'b0}}, dy[DST_W+1]});
        off_x  = dx_adj >>> 1;
        off_y  = dy_adj >>> 1;
    end

    // Destination column and row, optional point reflection, range check.
    always_comb
    begin
        col_s = PW'(s6_x_reg) + PW'(off_x) + PW'(wh_s);
        row_s = PW'(s6_y_reg) + PW'(off_y) + PW'(hh_s);
        if (cfg.mirror_flip)
        begin
            col_m = PW'(dw_s) - col_s - PW'(1);
            row_m = PW'(dh_s) - row_s - PW'(1);
        end
        else
        begin
            col_m = col_s;
            row_m = row_s;
        end
        pos_valid = (col_m >= 0) && (col_m < PW'(dw_s)) && (row_m >= 0) && (row_m < PW'(dh_s));
    end

    // Datapath stages: multiply, then add and truncate, three times over.
    always_ff @(posedge clk)
    begin
        s0_x_reg     <= q_item.x;
        s0_y_reg     <= q_item.y;
        s1_x_reg     <= s0_x_reg;
        s1_y_reg     <= s0_y_reg;
        s1_p_reg     <= PRW'(cfg.shear_a) * PRW'(s0_y_reg);
        s2_x_reg     <= shear_sum(CW'(s1_x_reg), s1_p_reg);
        s2_y_reg     <= s1_y_reg;
        s3_x_reg     <= s2_x_reg;
        s3_y_reg     <= s2_y_reg;
        s3_p_reg     <= PRW'(cfg.shear_b) * PRW'(s2_x_reg);
        s4_x_reg     <= s3_x_reg;
        s4_y_reg     <= shear_sum(CW'(s3_y_reg), s3_p_reg);
        s5_x_reg     <= s4_x_reg;
        s5_y_reg     <= s4_y_reg;
        s5_p_reg     <= PRW'(cfg.shear_a) * PRW'(s4_y_reg);
        s6_x_reg     <= shear_sum(s5_x_reg, s5_p_reg);
        s6_y_reg     <= s5_y_reg;
        s7_col_reg   <= col_m[DST_W-1:0];
        s7_row_reg   <= row_m[DST_W-1:0];
        s7_valid_reg <= pos_valid;
        s8_prod_reg  <= ADDR_W'(s7_row_reg) * ADDR_W'(cfg.dst_width);
        s8_col_reg   <= s7_col_reg;
        s8_valid_reg <= s7_valid_reg;
    end

    // Result beat.
    always_comb
    begin
        out_data.write_addr = s8_valid_reg ? s8_prod_reg + ADDR_W'(s8_col_reg) : '0;
        out_data.pixel      = meta_reg[STAGES-1].pixel;
        out_data.addr_valid = s8_valid_reg;
        out_data.last       = meta_reg[STAGES-1].last;
    end

`ifndef SYNTH
    // The in-flight count must track the stage valid bits.
    a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        int'(inflight_reg) == $countones(vld_reg))
        else $error("in-flight count out of step with pipeline");

    // Items in flight plus waiting results never exceed the result queue.
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(out_count) + int'(inflight_reg)) <= OUT_DEPTH)
        else $error("result queue overcommitted");

    // A suppressed write carries a zero address.
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_push && !out_data.addr_valid |-> out_data.write_addr == '0)
        else $error("invalid address not zeroed");

    // An issued item enters the first stage.
    a_issue: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> vld_reg[0])
        else $error("issued item lost");
`endif

endmodule

### rtl/three_shear_rotation_mapper.sv
// Top level of the three-shear rotation address mapper.
// Holds the configuration registers and joins front, middle queue, back and result queue.
// Depends on tsr_pkg, tsr_fifo, tsr_front and tsr_back.
//
// Usage:
//   Source pixels enter in memory order through push/full: a beat is taken when
//   push is high and full is low. Results leave through empty/pop: the oldest
//   result sits on write_addr, pixel_out, addr_valid and last_pixel while empty
//   is low, and is taken when pop is high. addr_valid low means the pixel lands
//   outside the destination and must not be written; write_addr is then zero.
//   Configuration registers are written through cfg_valid/cfg_ready with a
//   register index and data; cfg_ready is always high. Write them only while
//   no pixel is in flight.
// Timing:
//   One pixel per cycle sustained while the receiver keeps popping. An accepted
//   pixel passes the middle queue, the shear pipeline, whose three multiply and
//   add pairs lie among its stages, and then the result queue.
// Reset and stalls:
//   Reset empties both queues, clears the source counters and loads the
//   register defaults. When the receiver stops popping, the 16-entry result
//   queue absorbs the pipeline contents, the 4-entry front queue fills and full
//   rises; nothing is dropped.
module three_shear_rotation_mapper
    import tsr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [PIX_W-1:0]      pixel_in,
    output logic                  empty,
    input  logic                  pop,
    output logic [ADDR_W-1:0]     write_addr,
    output logic [PIX_W-1:0]      pixel_out,
    output logic                  addr_valid,
    output logic                  last_pixel,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ITEM_W   = $bits(item_t);
    localparam int RESULT_W = $bits(result_t);

    logic signed [COEF_W-1:0] shear_a_reg, shear_b_reg;
    logic [SRC_W-1:0]         src_width_reg, src_height_reg;
    logic [DST_W-1:0]         dst_width_reg, dst_height_reg;
    logic                     mirror_flip_reg;

    cfg_t                     cfg;
    item_t                    front_item, q_item;
    result_t                  back_result, out_result;
    logic                     accept, q_full, q_empty, q_pop, out_push;
    logic [MID_DEPTH_LOG2:0]  q_count;
    logic [OUT_DEPTH_LOG2:0]  out_count;
    logic                     out_full;
    logic [ITEM_W-1:0]        q_rdata;
    logic [RESULT_W-1:0]      out_rdata;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shear_a_reg     <= '0;
            shear_b_reg     <= '0;
            src_width_reg   <= SRC_DIM_RESET;
            src_height_reg  <= SRC_DIM_RESET;
            dst_width_reg   <= DST_DIM_RESET;
            dst_height_reg  <= DST_DIM_RESET;
            mirror_flip_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SHEAR_A:    shear_a_reg     <= $signed(cfg_data);
                REG_SHEAR_B:    shear_b_reg     <= $signed(cfg_data);
                REG_SRC_WIDTH:  src_width_reg   <= cfg_data[SRC_W-1:0];
                REG_SRC_HEIGHT: src_height_reg  <= cfg_data[SRC_W-1:0];
                REG_DST_WIDTH:  dst_width_reg   <= cfg_data[DST_W-1:0];
                REG_DST_HEIGHT: dst_height_reg  <= cfg_data[DST_W-1:0];
                REG_MIRROR:     mirror_flip_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Datapath view of the configuration, source sizes clamped.
    always_comb
    begin
        cfg.shear_a     = shear_a_reg;
        cfg.shear_b     = shear_b_reg;
        cfg.src_width   = clamp_dim(src_width_reg);
        cfg.src_height  = clamp_dim(src_height_reg);
        cfg.dst_width   = dst_width_reg;
        cfg.dst_height  = dst_height_reg;
        cfg.mirror_flip = mirror_flip_reg;
    end

    // Input handshake.
    assign full   = q_full;
    assign accept = push && !q_full;

    tsr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .pixel_in (pixel_in),
        .cfg      (cfg),
        .item     (front_item)
    );

    // Queue between front and back.
    tsr_fifo #(
        .WIDTH      (ITEM_W),
        .DEPTH_LOG2 (MID_DEPTH_LOG2)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (front_item),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty),
        .count (q_count)
    );

    assign q_item = item_t'(q_rdata);

    tsr_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_data  (back_result)
    );

    // Result queue.
    tsr_fifo #(
        .WIDTH      (RESULT_W),
        .DEPTH_LOG2 (OUT_DEPTH_LOG2)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (back_result),
        .pop   (pop),
        .rdata (out_rdata),
        .full  (out_full),
        .empty (empty),
        .count (out_count)
    );

    // Result ports.
    assign out_result = result_t'(out_rdata);
    assign write_addr = out_result.write_addr;
    assign pixel_out  = out_result.pixel;
    assign addr_valid = out_result.addr_valid;
    assign last_pixel = out_result.last;

`ifndef SYNTH
    // The back end never pushes into a full result queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result queue overflow");

    // The middle queue count stays within its depth.
    a_mid_count: assert property (@(posedge clk) disable iff (!rst_n)
        int'(q_count) <= (1 << MID_DEPTH_LOG2))
        else $error("middle queue count out of range");

    // From an idle state, a result is pushed only if the back pipeline held an item.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $past(q_count) == '0 && $past(out_count) == '0 && $past(q_pop) == 1'b0
        && $past(out_push) == 1'b0 |-> !out_push || $past(u_back.vld_reg) != '0)
        else $error("result without a source pixel");
`endif

endmodule

### test/tsr_checker.sv
// Scoreboard for the three-shear rotation mapper: it mirrors the configuration
// writes, predicts each destination write and compares it with what the block pops.
// Depends on tsr_pkg.
module tsr_checker
    import tsr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic [PIX_W-1:0]      pixel_in,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [ADDR_W-1:0]     write_addr,
    input  logic [PIX_W-1:0]      pixel_out,
    input  logic                  addr_valid,
    input  logic                  last_pixel,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the register file and of the source position counters.
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic [SRC_W-1:0]         src_w;
    logic [SRC_W-1:0]         src_h;
    logic [DST_W-1:0]         dst_w;
    logic [DST_W-1:0]         dst_h;
    logic                     mirror;
    logic [SRC_W-1:0]         col_cnt;
    logic [SRC_W-1:0]         row_cnt;

    // Destination writes predicted but not yet popped, oldest first.
    result_t expected_writes[$];

    // One shear: base plus k times other, k in fixed point, truncated toward zero.
    function automatic longint shear_step(input longint base, input longint k,
                                          input longint other);
        longint one;
        one = longint'(1) << FRAC_BITS;
        return (base * one + k * other) / one;
    endfunction

    // Source sizes outside the supported range are pulled to the nearest limit.
    function automatic longint src_extent(input logic [SRC_W-1:0] d);
        if (d < 2)
        begin
            return 2;
        end
        if (d > MAX_SRC_DIM)
        begin
            return MAX_SRC_DIM;
        end
        return longint'(d);
    endfunction

    // Predicts the write for one source pixel and steps the position counters.
    function automatic result_t rotate_pixel(input logic [PIX_W-1:0] pix);
        longint  sw, sh, wh, hh, col_end, row_end, c, r;
        longint  dw, dh, x, y, col, row;
        result_t res;
        sw      = src_extent(src_w);
        sh      = src_extent(src_h);
        wh      = sw / 2;
        hh      = sh / 2;
        col_end = wh * 2 - 1;
        row_end = hh * 2 - 1;
        // A counter left past the end by a size change counts as the last position.
        c = longint'(col_cnt);
        r = longint'(row_cnt);
        if (c > col_end)
        begin
            c = col_end;
        end
        if (r > row_end)
        begin
            r = row_end;
        end
        dw = longint'(dst_w);
        dh = longint'(dst_h);

        x = c - wh;
        y = r - hh;
        x = shear_step(x, longint'(coef_a), y);
        y = shear_step(y, longint'(coef_b), x);
        x = shear_step(x, longint'(coef_a), y);

        col = x + (dw - sw) / 2 + wh;
        row = y + (dh - sh) / 2 + hh;
        if (mirror)
        begin
            col = dw - 1 - col;
            row = dh - 1 - row;
        end

        res.addr_valid = (col >= 0) && (col < dw) && (row >= 0) && (row < dh);
        res.write_addr = res.addr_valid ? ADDR_W'(row * dw + col) : '0;
        res.pixel      = pix;
        res.last       = (c == col_end) && (r == row_end);

        if (c == col_end)
        begin
            col_cnt = '0;
            row_cnt = (r == row_end) ? '0 : SRC_W'(r + 1);
        end
        else
        begin
            col_cnt = SRC_W'(c + 1);
            row_cnt = SRC_W'(r);
        end
        return res;
    endfunction

    // Watch all three channels at each edge: register writes, pixel beats, result beats.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            coef_a      = '0;
            coef_b      = '0;
            src_w       = SRC_DIM_RESET;
            src_h       = SRC_DIM_RESET;
            dst_w       = DST_DIM_RESET;
            dst_h       = DST_DIM_RESET;
            mirror      = 1'b0;
            col_cnt     = '0;
            row_cnt     = '0;
            mismatches  = 0;
            outstanding = 0;
            expected_writes.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SHEAR_A:    coef_a = cfg_data;
                    REG_SHEAR_B:    coef_b = cfg_data;
                    REG_SRC_WIDTH:  src_w  = cfg_data[SRC_W-1:0];
                    REG_SRC_HEIGHT: src_h  = cfg_data[SRC_W-1:0];
                    REG_DST_WIDTH:  dst_w  = cfg_data[DST_W-1:0];
                    REG_DST_HEIGHT: dst_h  = cfg_data[DST_W-1:0];
                    REG_MIRROR:     mirror = cfg_data[0];
                    default:        ;
                endcase
            end

            if (push && !full)
            begin
                expected_writes.push_back(rotate_pixel(pixel_in));
            end

            if (pop && !empty)
            begin
                got.write_addr = write_addr;
                got.pixel      = pixel_out;
                got.addr_valid = addr_valid;
                got.last       = last_pixel;
                if (expected_writes.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: unexpected result beat addr=%0d pix=%0d valid=%0b last=%0b",
                                 $realtime, got.write_addr, got.pixel, got.addr_valid,
                                 got.last);
                    end
                    mismatches++;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (want.write_addr != got.write_addr || want.pixel != got.pixel ||
                        want.addr_valid != got.addr_valid || want.last != got.last)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: mismatch expected addr=%0d pix=%0d valid=%0b last=%0b",
                                     $realtime, want.write_addr, want.pixel,
                                     want.addr_valid, want.last);
                            $display("%0t:          got      addr=%0d pix=%0d valid=%0b last=%0b",
                                     $realtime, got.write_addr, got.pixel,
                                     got.addr_valid, got.last);
                        end
                        mismatches++;
                    end
                end
            end
            outstanding = expected_writes.size();
        end
    end

endmodule

### test/tb_top.sv
// Top of the three-shear rotation mapper testbench: clock, reset, register setup,
// pixel stimulus with random pacing, and the verdict.
// Depends on tsr_pkg, three_shear_rotation_mapper and tsr_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tsr_pkg::*;

    localparam int ITEMS      = 550;
    localparam int LIMIT      = 400000;
    localparam int LATENCY    = 12;
    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef enum logic [1:0] {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_t;

    typedef struct {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic [SRC_W-1:0]         sw;
        logic [SRC_W-1:0]         sh;
        logic [DST_W-1:0]         dw;
        logic [DST_W-1:0]         dh;
        logic                     mir;
    } setting_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  push       = 1'b0;
    logic                  full;
    logic [PIX_W-1:0]      pixel_in   = '0;
    logic                  empty;
    logic                  pop        = 1'b0;
    logic [ADDR_W-1:0]     write_addr;
    logic [PIX_W-1:0]      pixel_out;
    logic                  addr_valid;
    logic                  last_pixel;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    int        mismatches;
    int        outstanding;
    gap_mode_t gap_mode     = GAP_NONE;
    int        beats_in     = 0;
    int        beats_out    = 0;
    int        frames_done  = 0;
    int        settings_run = 0;
    int        cycles       = 0;

    three_shear_rotation_mapper DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel_in   (pixel_in),
        .empty      (empty),
        .pop        (pop),
        .write_addr (write_addr),
        .pixel_out  (pixel_out),
        .addr_valid (addr_valid),
        .last_pixel (last_pixel),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    tsr_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pixel_in    (pixel_in),
        .empty       (empty),
        .pop         (pop),
        .write_addr  (write_addr),
        .pixel_out   (pixel_out),
        .addr_valid  (addr_valid),
        .last_pixel  (last_pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Percentages of cycles in which each side holds back.
    function automatic int send_gap_pct();
        return (gap_mode == GAP_SEND) ? 57 : (gap_mode == GAP_BOTH) ? 21 : 0;
    endfunction

    function automatic int recv_stall_pct();
        return (gap_mode == GAP_RECV) ? 57 : (gap_mode == GAP_BOTH) ? 21 : 0;
    endfunction

    function automatic bit chance(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Receiver: pop with random stalls.
    always @(posedge clk)
    begin
        pop <= !chance(recv_stall_pct());
    end

    // Count result beats taken and frame ends seen.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            beats_out <= beats_out + 1;
            if (last_pixel)
            begin
                frames_done <= frames_done + 1;
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d of %0d results in.",
                     cycles, beats_out, beats_in);
            $display("FAILURE");
            $finish;
        end
    end

    // One register write beat; the caller lowers cfg_valid after its last write.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Loads every register; bits above a register's width carry random junk.
    task automatic apply_setting(input setting_t s, input bit poke_spare);
        put_reg(REG_SHEAR_A, s.a);
        put_reg(REG_SHEAR_B, s.b);
        put_reg(REG_SRC_WIDTH, {7'($urandom), s.sw});
        put_reg(REG_SRC_HEIGHT, {7'($urandom), s.sh});
        put_reg(REG_DST_WIDTH, {6'($urandom), s.dw});
        put_reg(REG_DST_HEIGHT, {6'($urandom), s.dh});
        if (poke_spare)
        begin
            put_reg(REG_SPARE, 16'($urandom));
        end
        put_reg(REG_MIRROR, {15'($urandom), s.mir});
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // One pixel beat, preceded by a random gap; push stays high if the next beat follows.
    task automatic send_pixel(input logic [PIX_W-1:0] value);
        while (chance(send_gap_pct()))
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push     <= 1'b1;
        pixel_in <= value;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        beats_in++;
    endtask

    // Ends a burst and waits until every result has been taken.
    task automatic drain();
        push <= 1'b0;
        while (beats_out != beats_in)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random(input int count);
        repeat (count)
        begin
            send_pixel(PIX_W'($urandom_range(255)));
        end
        drain();
    endtask

    function automatic setting_t random_setting();
        setting_t s;
        s.a   = chance(12) ? 16'($urandom) : 16'(int'($urandom_range(32768)) - 16384);
        s.b   = chance(12) ? 16'($urandom) : 16'(int'($urandom_range(32768)) - 16384);
        s.sw  = chance(10) ? 9'($urandom_range(1)) :
                chance(8)  ? 9'(MAX_SRC_DIM) : 9'($urandom_range(2, 9));
        s.sh  = chance(10) ? 9'($urandom_range(1)) :
                chance(8)  ? 9'(MAX_SRC_DIM) : 9'($urandom_range(2, 9));
        s.dw  = chance(10) ? 10'd0 : chance(10) ? 10'd1023 : 10'($urandom_range(1, 24));
        s.dh  = chance(10) ? 10'd0 : chance(10) ? 10'd1023 : 10'($urandom_range(1, 24));
        s.mir = 1'($urandom_range(1));
        return s;
    endfunction

    // Stimulus.
    initial
    begin
        setting_t s;
        int       phase;
        int       fw;
        int       fh;
        int       count;
        phase = 0;

        repeat (6)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: one 2x2 frame with the pixel extremes.
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h55);
        send_pixel(8'hAA);
        drain();

        // Source sizes below the minimum, full positive and negative shears, mirrored.
        s = '{a: 16'sd16384, b: -16'sd16384, sw: 9'd1, sh: 9'd0, dw: 10'd3, dh: 10'd5,
              mir: 1'b1};
        apply_setting(s, 1'b0);
        send_random(4);

        // Largest source and destination, coefficients at the 16-bit ends; partial frame.
        s = '{a: 16'sh8000, b: 16'sh7FFF, sw: 9'd511, sh: 9'd511, dw: 10'd1023, dh: 10'd1023,
              mir: 1'b0};
        apply_setting(s, 1'b0);
        send_random(5);

        // Shrink the source mid-frame so the column counter sits past its end;
        // zero destination width means no write is ever in range.
        s = '{a: 16'sd8192, b: -16'sd8192, sw: 9'd3, sh: 9'd5, dw: 10'd0, dh: 10'd7,
              mir: 1'b0};
        apply_setting(s, 1'b1);
        send_random(4);

        // Zero destination height, no rotation, mirrored.
        s = '{a: 16'sd0, b: 16'sd0, sw: 9'd8, sh: 9'd2, dw: 10'd1023, dh: 10'd0, mir: 1'b1};
        apply_setting(s, 1'b0);
        send_random(4);

        // Random settings, mostly whole frames, cycling through the pacing modes.
        while (beats_in < ITEMS)
        begin
            s = random_setting();
            gap_mode <= gap_mode_t'(phase % 4);
            apply_setting(s, chance(10));
            fw    = ((s.sw < 2) ? 2 : s.sw) / 2 * 2;
            fh    = ((s.sh < 2) ? 2 : s.sh) / 2 * 2;
            count = (fw * fh > 80) ? $urandom_range(10, 30) : fw * fh;
            send_random(count);
            phase++;
        end

        drain();
        repeat (LATENCY)
        begin
            @(posedge clk);
        end

        $display("Run covered %0d pixels over %0d register settings and %0d frame ends,",
                 beats_in, settings_run, frames_done);
        $display("with %0d result mismatches and %0d results still owed.",
                 mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
rtl/tsr_pkg.sv
rtl/tsr_fifo.sv
rtl/tsr_front.sv
rtl/tsr_back.sv
rtl/three_shear_rotation_mapper.sv
test/tsr_checker.sv
test/tb_top.sv
